// ----- src/led_strip_pattern_generator_unit_defines.svh -----
// ----------------------------------------------------------------------------
// led strip pattern generator assertion macros
// shared property shorthands, sampled on clk and disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef LED_STRIP_PATTERN_GENERATOR_UNIT_DEFINES_SVH
`define LED_STRIP_PATTERN_GENERATOR_UNIT_DEFINES_SVH

// same-cycle implication
`define LSPG_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LSPG_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// implication after a fixed number of cycles
`define LSPG_ASSERT_LAT(label, ante, dly, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
    else $error(msg);

`endif

// ----- src/lspg_pkg.sv -----
// ----------------------------------------------------------------------------
// lspg_pkg
// types, constants and small color functions of the led strip pattern generator
// ----------------------------------------------------------------------------
package lspg_pkg;

  localparam int MAX_PIXELS      = 1024;
  localparam int PULSE_PERIOD_MS = 2000;

  localparam int MID_DEPTH     = 4;
  localparam int OUT_DEPTH     = 16;
  localparam int DIV_STAGES    = 11;
  localparam int PULSE_STAGES  = 7;

  typedef logic [23:0] color_t;

  localparam color_t COLOR_OFF   = 24'h000000;
  localparam color_t COLOR_RED   = 24'hFF0000;
  localparam color_t COLOR_WHITE = 24'hFFFFFF;

  typedef enum logic [2:0] {
    MODE_SOLID,
    MODE_RAINBOW,
    MODE_CYCLE,
    MODE_CHASE,
    MODE_CHASE_RB,
    MODE_DOT,
    MODE_PROGRESS
  } mode_t;

  typedef enum logic [1:0] {
    REG_MODE,
    REG_BASE,
    REG_COUNT,
    REG_PROGRESS
  } reg_idx_t;

  typedef struct packed {
    logic [9:0]  pixel_index;
    logic [10:0] frame_step;
    logic [1:0]  chase_phase;
    logic [31:0] time_ms;
  } in_t;

  typedef struct packed {
    color_t      pixel_color;
    logic [9:0]  pixel_index_out;
  } out_t;

  typedef struct packed {
    logic [2:0]  pattern_mode;
    color_t      base_color;
    logic [10:0] pixel_count;
    logic [16:0] progress_fraction;
  } cfg_t;

  // classified item handed from front to back
  typedef struct packed {
    logic [2:0]  mode;
    logic [9:0]  pixel_index;
    logic [10:0] frame_step;
    logic [31:0] time_ms;
    logic        on_strip;
    logic        chase_hit;
    logic [7:0]  wheel_pos;
    logic [10:0] div_rem;
    logic [10:0] div_bits;
  } cls_t;

  function automatic color_t color_wheel(logic [7:0] pos);
    logic [7:0] v;
    logic [7:0] v3;
    v = ~pos;
    if (v < 8'd85) begin
      v3 = v * 8'd3;
      return {8'd255 - v3, 8'd0, v3};
    end else if (v < 8'd170) begin
      v3 = (v - 8'd85) * 8'd3;
      return {8'd0, v3, 8'd255 - v3};
    end else begin
      v3 = (v - 8'd170) * 8'd3;
      return {v3, 8'd255 - v3, 8'd0};
    end
  endfunction

  // base-4 digit sum, then fold
  function automatic logic [1:0] mod3(logic [9:0] p);
    logic [3:0] s;
    logic [2:0] t;
    s = 4'(p[1:0]) + 4'(p[3:2]) + 4'(p[5:4]) + 4'(p[7:6]) + 4'(p[9:8]);
    t = 3'(s[3:2]) + 3'(s[1:0]);
    if (t >= 3'd6) begin
      return 2'd0;
    end else if (t >= 3'd3) begin
      return 2'(t - 3'd3);
    end else begin
      return t[1:0];
    end
  endfunction

  // 256 = 1 mod 255
  function automatic logic [7:0] mod255(logic [11:0] x);
    logic [8:0] s;
    s = 9'(x[11:8]) + 9'(x[7:0]);
    if (s >= 9'd255) begin
      s = s - 9'd255;
    end
    return s[7:0];
  endfunction

  function automatic logic [10:0] eff_count(logic [10:0] pc);
    if (pc == 11'd0) begin
      return 11'd1;
    end else if (int'(pc) > MAX_PIXELS) begin
      return 11'(MAX_PIXELS);
    end else begin
      return pc;
    end
  endfunction

endpackage

// ----- src/led_strip_pattern_generator_unit.sv -----
// ----------------------------------------------------------------------------
// led_strip_pattern_generator_unit
// per-pixel rgb pattern generator with apb register port
// ----------------------------------------------------------------------------
//   channel   ports                              beat
//   request   push / full / in_item              in_t: pixel, frame, phase, time
//   result    pop / empty / out_item             out_t: color, pixel
//   config    psel penable pwrite paddr pwdata   32-bit registers at 4*i
//
// one beat per cycle sustained while results are popped; an accepted beat
// passes the request queue and the 11-step remainder pipeline to the results.
// synchronous active-low reset clears registers to defaults and empties queues.
// up to 16 results wait for pop; beyond that the back end stops issuing and
// full rises once the 4-entry request queue fills.
// ----------------------------------------------------------------------------
module led_strip_pattern_generator_unit (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  output logic           full,
  input  lspg_pkg::in_t  in_item,
  input  logic           pop,
  output logic           empty,
  output lspg_pkg::out_t out_item,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [3:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);
  import lspg_pkg::*;

  cfg_t  cfg_r, cfg_nxt;
  logic  cfg_wr;

  logic  q_wr;
  logic  q_full;
  logic  q_empty;
  logic  q_rd;
  cls_t  q_wdata;
  cls_t  q_rdata;

  logic  res_wr;
  logic  res_full;
  logic  res_pop_ok;
  out_t  res_wdata;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      unique case (reg_idx_t'(paddr[3:2]))
        REG_MODE:     cfg_nxt.pattern_mode      = pwdata[2:0];
        REG_BASE:     cfg_nxt.base_color        = pwdata[23:0];
        REG_COUNT:    cfg_nxt.pixel_count       = pwdata[10:0];
        REG_PROGRESS: cfg_nxt.progress_fraction = pwdata[16:0];
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_t'(paddr[3:2]))
      REG_MODE:     prdata = 32'(cfg_r.pattern_mode);
      REG_BASE:     prdata = 32'(cfg_r.base_color);
      REG_COUNT:    prdata = 32'(cfg_r.pixel_count);
      REG_PROGRESS: prdata = 32'(cfg_r.progress_fraction);
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pattern_mode      <= 3'd0;
      cfg_r.base_color        <= 24'd0;
      cfg_r.pixel_count       <= 11'd64;
      cfg_r.progress_fraction <= 17'd0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  lspg_front u_front (
    .cfg     (cfg_r),
    .push    (push),
    .in_item (in_item),
    .q_full  (q_full),
    .full    (full),
    .q_wr    (q_wr),
    .q_data  (q_wdata)
  );

  lspg_fifo #(
    .WIDTH ($bits(cls_t)),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_wr),
    .wr_data (q_wdata),
    .full    (q_full),
    .rd_en   (q_rd),
    .rd_data (q_rdata),
    .empty   (q_empty)
  );

  assign res_pop_ok = pop && !empty;

  lspg_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_empty    (q_empty),
    .q_data     (q_rdata),
    .q_rd       (q_rd),
    .out_pop_ok (res_pop_ok),
    .out_full   (res_full),
    .out_wr     (res_wr),
    .out_data   (res_wdata)
  );

  lspg_fifo #(
    .WIDTH ($bits(out_t)),
    .DEPTH (OUT_DEPTH)
  ) u_res_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (res_wr),
    .wr_data (res_wdata),
    .full    (res_full),
    .rd_en   (res_pop_ok),
    .rd_data (out_item),
    .empty   (empty)
  );

endmodule

// ----- src/lspg_fifo.sv -----
// ----------------------------------------------------------------------------
// lspg_fifo
// small register queue with show-ahead read; depth must be a power of two
// ----------------------------------------------------------------------------
`include "led_strip_pattern_generator_unit_defines.svh"

module lspg_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_en ? wr_ptr_r + AW'(1) : wr_ptr_r;
    rd_ptr_nxt = rd_en ? rd_ptr_r + AW'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + CW'(wr_en) - CW'(rd_en);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  `LSPG_ASSERT_NXT(a_fifo_fill, wr_en && !rd_en, !empty, "queue empty after write")
  `LSPG_ASSERT_NXT(a_fifo_drain, rd_en && !wr_en && cnt_r == CW'(1), empty,
                   "queue not empty after last read")

endmodule

// ----- src/lspg_front.sv -----
// ----------------------------------------------------------------------------
// lspg_front
// accepts request beats and classifies them for the color pipeline
// ----------------------------------------------------------------------------
module lspg_front (
  input  lspg_pkg::cfg_t cfg,
  input  logic           push,
  input  lspg_pkg::in_t  in_item,
  input  logic           q_full,
  output logic           full,
  output logic           q_wr,
  output lspg_pkg::cls_t q_data
);
  import lspg_pkg::*;

  logic [10:0] n;
  logic [1:0]  pm3;
  logic [7:0]  pos_rb;
  logic [11:0] chase_sum;
  logic [7:0]  pos_crb;
  logic        is_cycle;

  assign full = q_full;
  assign q_wr = push && !q_full;

  always_comb begin
    n         = eff_count(cfg.pixel_count);
    pm3       = mod3(in_item.pixel_index);
    pos_rb    = in_item.pixel_index[7:0] + in_item.frame_step[7:0];
    // p - q only matters when p mod 3 == q, so it never goes negative there
    chase_sum = 12'(in_item.pixel_index) - 12'(in_item.chase_phase)
              + 12'(in_item.frame_step);
    pos_crb   = mod255(chase_sum);
    is_cycle  = (mode_t'(cfg.pattern_mode) == MODE_CYCLE);

    q_data.mode        = cfg.pattern_mode;
    q_data.pixel_index = in_item.pixel_index;
    q_data.frame_step  = in_item.frame_step;
    q_data.time_ms     = in_item.time_ms;
    q_data.on_strip    = ({1'b0, in_item.pixel_index} < n);
    q_data.chase_hit   = (pm3 == in_item.chase_phase);
    q_data.wheel_pos   = (mode_t'(cfg.pattern_mode) == MODE_CHASE_RB) ? pos_crb : pos_rb;
    // rainbow cycle: divide p*256 by n, seeding the remainder with p>>3
    // everything else: j mod n
    if (is_cycle) begin
      q_data.div_rem  = {4'd0, in_item.pixel_index[9:3]};
      q_data.div_bits = {in_item.pixel_index[2:0], 8'd0};
    end else begin
      q_data.div_rem  = '0;
      q_data.div_bits = in_item.frame_step;
    end
  end

endmodule

// ----- src/lspg_back.sv -----
// ----------------------------------------------------------------------------
// lspg_back
// color pipeline: restoring divider stages, gray pulse lane and final select
// ----------------------------------------------------------------------------
`include "led_strip_pattern_generator_unit_defines.svh"

module lspg_back (
  input  logic           clk,
  input  logic           rst_n,
  input  lspg_pkg::cfg_t cfg,
  input  logic           q_empty,
  input  lspg_pkg::cls_t q_data,
  output logic           q_rd,
  input  logic           out_pop_ok,
  input  logic           out_full,
  output logic           out_wr,
  output lspg_pkg::out_t out_data
);
  import lspg_pkg::*;

  localparam int RW   = $clog2(OUT_DEPTH + 1);
  localparam int LAT  = DIV_STAGES + 1;
  localparam int GDLY = DIV_STAGES + 1 - PULSE_STAGES;

  localparam logic [15:0] PERIOD  = 16'(PULSE_PERIOD_MS);
  localparam logic [15:0] HALF    = 16'(PULSE_PERIOD_MS / 2);
  localparam logic [31:0] RECIP_T = 32'((64'd1 << 32) / PULSE_PERIOD_MS);
  localparam logic [23:0] RECIP_G = 24'((64'd1 << 24) / PULSE_PERIOD_MS);

  // credits: beats in the pipeline plus beats in the output queue
  logic [RW-1:0] reserved_r, reserved_nxt;
  logic          issue;

  // config-derived values
  logic [10:0] n_r;
  logic [26:0] kprod_r;
  logic [10:0] k;

  // main line
  logic        s_vld_r  [DIV_STAGES+1];
  cls_t        s_item_r [DIV_STAGES+1];
  logic [10:0] s_rem_r  [DIV_STAGES+1];
  logic [10:0] s_bits_r [DIV_STAGES+1];
  logic [7:0]  s_quo_r  [DIV_STAGES+1];
  logic [10:0] rem_nxt  [DIV_STAGES+1];
  logic [10:0] bits_nxt [DIV_STAGES+1];
  logic [7:0]  quo_nxt  [DIV_STAGES+1];

  // gray pulse lane
  logic [63:0] pa_prod_r;
  logic [31:0] pa_tm_r;
  logic [47:0] pb_qp_r;
  logic [31:0] pb_tm_r;
  logic [15:0] pc_t_r;
  logic [23:0] pd_y_r;
  logic [47:0] pe_prod_r;
  logic [23:0] pe_y_r;
  logic [25:0] pf_q2p_r;
  logic [9:0]  pf_q2_r;
  logic [23:0] pf_y_r;
  logic [7:0]  pg_gray_r;
  logic [7:0]  gdly_r [GDLY];

  logic [17:0] t_diff;
  logic [15:0] t_nxt;
  logic [15:0] x_val;
  logic [23:0] y_nxt;
  logic [23:0] rem2;
  logic [9:0]  q2c;
  logic [7:0]  gray_nxt;

  // output select
  cls_t        f;
  logic [10:0] dot_pos;
  logic [10:0] dot_prev;
  logic [7:0]  gray;
  color_t      color;

  assign issue = !q_empty && (reserved_r < RW'(OUT_DEPTH));
  assign q_rd  = issue;
  assign k     = kprod_r[26:16];

  always_comb begin
    reserved_nxt = reserved_r + RW'(issue) - RW'(out_pop_ok);
  end

  always_comb begin : div_steps
    logic [11:0] r2;
    logic        ge;
    rem_nxt[0]  = q_data.div_rem;
    bits_nxt[0] = q_data.div_bits;
    quo_nxt[0]  = '0;
    for (int i = 1; i <= DIV_STAGES; i++) begin
      r2          = {s_rem_r[i-1], s_bits_r[i-1][10]};
      ge          = (r2 >= {1'b0, n_r});
      rem_nxt[i]  = ge ? 11'(r2 - {1'b0, n_r}) : r2[10:0];
      bits_nxt[i] = {s_bits_r[i-1][9:0], 1'b0};
      quo_nxt[i]  = {s_quo_r[i-1][6:0], ge};
    end
  end

  always_comb begin
    // quotient estimate is low by at most one, so one fixup each time
    t_diff   = 18'(pb_tm_r - pb_qp_r[31:0]);
    t_nxt    = 16'((t_diff >= {2'b00, PERIOD}) ? t_diff - {2'b00, PERIOD} : t_diff);
    x_val    = (pc_t_r < HALF) ? pc_t_r : PERIOD - pc_t_r;
    y_nxt    = 24'(x_val) * 24'd510 + 24'(PERIOD) - 24'd1;
    rem2     = pf_y_r - pf_q2p_r[23:0];
    q2c      = (rem2 >= 24'(PERIOD)) ? pf_q2_r + 10'd1 : pf_q2_r;
    gray_nxt = (q2c > 10'd255) ? 8'd255 : q2c[7:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reserved_r <= '0;
      for (int i = 0; i <= DIV_STAGES; i++) begin
        s_vld_r[i] <= 1'b0;
      end
    end else begin
      reserved_r <= reserved_nxt;
      s_vld_r[0] <= issue;
      for (int i = 1; i <= DIV_STAGES; i++) begin
        s_vld_r[i] <= s_vld_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    n_r     <= eff_count(cfg.pixel_count);
    kprod_r <= 27'(n_r) * 27'(cfg.progress_fraction[15:0]);

    s_item_r[0] <= q_data;
    for (int i = 1; i <= DIV_STAGES; i++) begin
      s_item_r[i] <= s_item_r[i-1];
    end
    for (int i = 0; i <= DIV_STAGES; i++) begin
      s_rem_r[i]  <= rem_nxt[i];
      s_bits_r[i] <= bits_nxt[i];
      s_quo_r[i]  <= quo_nxt[i];
    end

    pa_prod_r <= 64'(q_data.time_ms) * 64'(RECIP_T);
    pa_tm_r   <= q_data.time_ms;
    pb_qp_r   <= 48'(pa_prod_r[63:32]) * 48'(PERIOD);
    pb_tm_r   <= pa_tm_r;
    pc_t_r    <= t_nxt;
    pd_y_r    <= y_nxt;
    pe_prod_r <= 48'(pd_y_r) * 48'(RECIP_G);
    pe_y_r    <= pd_y_r;
    pf_q2_r   <= pe_prod_r[33:24];
    pf_q2p_r  <= 26'(pe_prod_r[33:24]) * 26'(PERIOD);
    pf_y_r    <= pe_y_r;
    pg_gray_r <= gray_nxt;
    gdly_r[0] <= pg_gray_r;
    for (int i = 1; i < GDLY; i++) begin
      gdly_r[i] <= gdly_r[i-1];
    end
  end

  always_comb begin
    f        = s_item_r[DIV_STAGES];
    dot_pos  = s_rem_r[DIV_STAGES];
    dot_prev = (dot_pos == 11'd0) ? n_r - 11'd1 : dot_pos - 11'd1;
    gray     = gdly_r[GDLY-1];
    color    = COLOR_OFF;
    unique case (mode_t'(f.mode))
      MODE_SOLID:    color = cfg.base_color;
      MODE_RAINBOW:  color = color_wheel(f.wheel_pos);
      MODE_CYCLE:    color = color_wheel(s_quo_r[DIV_STAGES] + f.frame_step[7:0]);
      MODE_CHASE:    color = f.chase_hit ? cfg.base_color : COLOR_OFF;
      MODE_CHASE_RB: color = f.chase_hit ? color_wheel(f.wheel_pos) : COLOR_OFF;
      MODE_DOT: begin
        // red wins over white on a one-pixel strip
        priority if ({1'b0, f.pixel_index} == dot_pos) begin
          color = COLOR_RED;
        end else if ({1'b0, f.pixel_index} == dot_prev) begin
          color = COLOR_WHITE;
        end else begin
          color = COLOR_OFF;
        end
      end
      MODE_PROGRESS: begin
        priority if (cfg.progress_fraction[16]) begin
          color = cfg.base_color;
        end else if ({1'b0, f.pixel_index} < k) begin
          color = cfg.base_color;
        end else if ({1'b0, f.pixel_index} == k) begin
          color = {gray, gray, gray};
        end else begin
          color = COLOR_OFF;
        end
      end
      default:       color = COLOR_OFF;
    endcase
    if (!f.on_strip) begin
      color = COLOR_OFF;
    end
  end

  assign out_wr                   = s_vld_r[DIV_STAGES];
  assign out_data.pixel_color     = color;
  assign out_data.pixel_index_out = f.pixel_index;

  `LSPG_ASSERT_LAT(a_back_latency, issue, LAT, out_wr, "beat lost in color pipeline")
  `LSPG_ASSERT_IMP(a_back_room, out_wr, !out_full, "result written into full queue")
  `LSPG_ASSERT_IMP(a_back_credit, reserved_r == '0, !out_wr, "result without credit")

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Checks the led strip pattern generator unit against a predictor of its own.
// Pixel requests are queued by phase and fed in bursts. The register file is
// rewritten over the apb port between phases, once the unit has drained.
// Every result is compared field by field with the oldest expected color.
// Pop stalls follow a rotating pattern, with one long hold-off that fills
// the unit and makes it stall its input.
// ----------------------------------------------------------------------------
module tb;
  import lspg_pkg::*;

  localparam logic [2:0] MODE_UNUSED   = 3'd7;
  localparam int         RANDOM_ITEMS  = 1900;
  localparam int         SETTLE_CYCLES = 20;
  localparam int         HOLD_CYCLES   = 400;
  localparam int         CYCLE_LIMIT   = 300000;

  logic        clk      = 1'b0;
  logic        rst_n    = 1'b0;
  logic        push     = 1'b0;
  logic        full;
  in_t         in_item  = '0;
  logic        pop      = 1'b0;
  logic        empty;
  out_t        out_item;
  logic        psel     = 1'b0;
  logic        penable  = 1'b0;
  logic        pwrite   = 1'b0;
  logic [3:0]  paddr    = '0;
  logic [31:0] pwdata   = '0;
  logic [31:0] prdata;
  logic        pready;

  // register shadow used by the predictor
  logic [2:0]  sh_mode  = MODE_SOLID;
  color_t      sh_base  = COLOR_OFF;
  logic [10:0] sh_count = 11'd64;
  logic [16:0] sh_frac  = '0;

  in_t  pix_requests[$];
  out_t exp_pixels[$];

  int unsigned errors     = 0;
  int unsigned cycles     = 0;
  int unsigned hold_go    = 0;
  int unsigned hold_seen  = 0;
  int unsigned hold_left  = 0;
  int unsigned burst_left = 8;
  int unsigned gap_left   = 0;
  logic [8:0]  rx_cyc     = '0;
  logic        took       = 1'b0;

  led_strip_pattern_generator_unit DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_item  (in_item),
    .pop      (pop),
    .empty    (empty),
    .out_item (out_item),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int unsigned strip_len();
    if (sh_count == 0) return 1;
    if (sh_count > MAX_PIXELS) return MAX_PIXELS;
    return sh_count;
  endfunction

  function automatic color_t wheel_rgb(int unsigned w);
    int unsigned v;
    v = 255 - (w & 255);
    if (v < 85) return {8'(255 - 3 * v), 8'h00, 8'(3 * v)};
    if (v < 170) return {8'h00, 8'(3 * (v - 85)), 8'(255 - 3 * (v - 85))};
    return {8'(3 * (v - 170)), 8'(255 - 3 * (v - 170)), 8'h00};
  endfunction

  // triangular gray pulse, rounded up
  function automatic color_t pulse_level(logic [31:0] ms);
    int unsigned t, x, g;
    t = ms % PULSE_PERIOD_MS;
    x = (t < PULSE_PERIOD_MS / 2) ? t : PULSE_PERIOD_MS - t;
    g = (x * 510 + PULSE_PERIOD_MS - 1) / PULSE_PERIOD_MS;
    if (g > 255) g = 255;
    return {3{8'(g)}};
  endfunction

  function automatic out_t predict_pixel(in_t req);
    int unsigned p, j, q, n, pos, k;
    out_t r;
    p = req.pixel_index;
    j = req.frame_step;
    q = req.chase_phase;
    n = strip_len();
    r.pixel_index_out = req.pixel_index;
    r.pixel_color     = COLOR_OFF;
    if (p < n) begin
      case (sh_mode)
        MODE_SOLID:    r.pixel_color = sh_base;
        MODE_RAINBOW:  r.pixel_color = wheel_rgb(p + j);
        MODE_CYCLE:    r.pixel_color = wheel_rgb(p * 256 / n + j);
        MODE_CHASE:    if (p % 3 == q) r.pixel_color = sh_base;
        MODE_CHASE_RB: if (p % 3 == q) r.pixel_color = wheel_rgb((p - q + j) % 255);
        MODE_DOT: begin
          pos = j % n;
          if (p == pos) r.pixel_color = COLOR_RED;
          else if (p == ((pos == 0) ? n - 1 : pos - 1)) r.pixel_color = COLOR_WHITE;
        end
        MODE_PROGRESS: begin
          if (sh_frac >= 17'd65536) begin
            r.pixel_color = sh_base;
          end else begin
            k = (n * sh_frac) >> 16;
            if (p < k) r.pixel_color = sh_base;
            else if (p == k) r.pixel_color = pulse_level(req.time_ms);
          end
        end
        default: ;
      endcase
    end
    return r;
  endfunction

  task automatic reg_write(reg_idx_t idx, logic [31:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // only touch registers once the unit has drained
  task automatic configure(logic [2:0] mode, color_t base, logic [10:0] count,
                           logic [16:0] frac);
    while (pix_requests.size() != 0 || exp_pixels.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    reg_write(REG_MODE, 32'(mode));
    reg_write(REG_BASE, 32'(base));
    reg_write(REG_COUNT, 32'(count));
    reg_write(REG_PROGRESS, 32'(frac));
    sh_mode  = mode;
    sh_base  = base;
    sh_count = count;
    sh_frac  = frac;
  endtask

  task automatic queue_pixel(int unsigned p, int unsigned j, int unsigned q,
                             logic [31:0] t);
    in_t req;
    req.pixel_index = 10'(p);
    req.frame_step  = 11'(j);
    req.chase_phase = 2'(q);
    req.time_ms     = t;
    pix_requests.push_back(req);
  endtask

  // sender: bursts of beats with random gaps, holds a beat while full
  always @(negedge clk) begin
    if (!rst_n) begin
      push <= 1'b0;
    end else if (push && !took) begin
      // beat not taken yet, keep it on the bus
    end else begin
      if (took) begin
        burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
      if (gap_left > 0) begin
        gap_left--;
        push <= 1'b0;
      end else if (pix_requests.size() > 0) begin
        push    <= 1'b1;
        in_item <= pix_requests[0];
      end else begin
        push <= 1'b0;
      end
    end
  end

  // receiver: rotating stall pattern plus the long hold-off on request
  always @(negedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      if (hold_seen != hold_go) begin
        hold_seen = hold_go;
        hold_left = HOLD_CYCLES;
      end
      rx_cyc++;
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        case (rx_cyc[8:7])
          2'd0:    pop <= 1'b1;
          2'd1:    pop <= ($urandom_range(0, 2) != 0);
          2'd2:    pop <= rx_cyc[1];
          default: pop <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // log accepted requests, then check the result beat
  always @(posedge clk) begin
    out_t exp_px;
    took = rst_n && push && !full;
    if (took) begin
      exp_pixels.push_back(predict_pixel(in_item));
      void'(pix_requests.pop_front());
    end
    if (rst_n && pop && !empty) begin
      if (exp_pixels.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: color %06h pixel %0d",
                   out_item.pixel_color, out_item.pixel_index_out);
      end else begin
        exp_px = exp_pixels.pop_front();
        if (out_item.pixel_color !== exp_px.pixel_color ||
            out_item.pixel_index_out !== exp_px.pixel_index_out) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: expected color %06h pixel %0d, got color %06h pixel %0d",
                     exp_px.pixel_color, exp_px.pixel_index_out,
                     out_item.pixel_color, out_item.pixel_index_out);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL led_strip_pattern_generator_unit");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned total, phase, cnt, n, k, p, j, sel;
    logic [2:0]  mode;
    color_t      base;
    logic [10:0] count;
    logic [16:0] frac;
    logic [31:0] t;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // field extremes, off-strip pixels and count clamping
    configure(MODE_SOLID, COLOR_WHITE, 11'd1024, 17'd0);
    queue_pixel(0, 0, 0, 32'h0);
    queue_pixel(1023, 1279, 3, 32'hFFFFFFFF);
    configure(MODE_SOLID, 24'h5A3C96, 11'd0, 17'd0);
    queue_pixel(0, 7, 1, 32'h1234);
    queue_pixel(1, 7, 1, 32'h1234);
    configure(MODE_RAINBOW, COLOR_OFF, 11'd2047, 17'd0);
    queue_pixel(1023, 1279, 0, 32'h0);
    queue_pixel(0, 0, 2, 32'h0);
    configure(MODE_CYCLE, COLOR_OFF, 11'd3, 17'd0);
    queue_pixel(2, 1279, 0, 32'h0);
    queue_pixel(0, 5, 0, 32'h0);
    // chase: lit, unlit and phase three
    configure(MODE_CHASE, 24'h0000A5, 11'd1024, 17'd0);
    queue_pixel(4, 0, 1, 32'h0);
    queue_pixel(4, 0, 0, 32'h0);
    queue_pixel(3, 0, 3, 32'h0);
    configure(MODE_CHASE_RB, COLOR_OFF, 11'd1024, 17'd0);
    queue_pixel(1022, 1279, 2, 32'h0);
    queue_pixel(0, 0, 0, 32'h0);
    queue_pixel(5, 9, 3, 32'h0);
    // single pixel dot: red wins over white
    configure(MODE_DOT, COLOR_OFF, 11'd1, 17'd0);
    queue_pixel(0, 1279, 0, 32'h0);
    configure(MODE_DOT, COLOR_OFF, 11'd10, 17'd0);
    queue_pixel(9, 10, 0, 32'h0);
    queue_pixel(0, 10, 0, 32'h0);
    queue_pixel(5, 10, 0, 32'h0);
    configure(MODE_PROGRESS, 24'h10E0F0, 11'd1024, 17'd65536);
    queue_pixel(1023, 0, 0, 32'h0);
    configure(MODE_PROGRESS, 24'h10E0F0, 11'd1024, 17'd32768);
    queue_pixel(511, 0, 0, 32'd1000);
    queue_pixel(512, 0, 0, 32'd1000);
    queue_pixel(512, 0, 0, 32'd1);
    queue_pixel(513, 0, 0, 32'd1000);
    configure(MODE_UNUSED, COLOR_WHITE, 11'd64, 17'd0);
    queue_pixel(0, 0, 0, 32'h0);

    total = 0;
    phase = 0;
    while (total < RANDOM_ITEMS) begin
      mode = ($urandom_range(0, 15) == 0) ? MODE_UNUSED : 3'($urandom_range(0, 6));
      sel  = $urandom_range(0, 5);
      base = (sel == 0) ? COLOR_OFF : (sel == 1) ? COLOR_WHITE : color_t'($urandom);
      sel  = $urandom_range(0, 9);
      case (sel)
        0:       count = 11'd0;
        1:       count = 11'd1;
        2:       count = 11'd1024;
        3:       count = 11'd2047;
        4:       count = 11'($urandom_range(1025, 2047));
        5, 6:    count = 11'($urandom_range(2, 12));
        default: count = 11'($urandom_range(1, 1024));
      endcase
      sel = $urandom_range(0, 7);
      case (sel)
        0:       frac = 17'd0;
        1:       frac = 17'd65535;
        2:       frac = 17'd65536;
        3:       frac = 17'($urandom_range(65537, 131071));
        default: frac = 17'($urandom_range(0, 65535));
      endcase
      configure(mode, base, count, frac);

      n   = strip_len();
      k   = (n * sh_frac) >> 16;
      cnt = (phase == 2) ? 300 : $urandom_range(30, 70);
      // long receiver hold-off while this phase is offered
      if (phase == 2) hold_go++;
      repeat (cnt) begin
        j   = $urandom_range(0, 1279);
        sel = $urandom_range(0, 7);
        if (sel == 0)
          p = $urandom_range(0, 1023);
        else if (sh_mode == MODE_PROGRESS && sel < 4)
          p = (k + $urandom_range(0, 2) + 1023) % 1024;
        else if (sh_mode == MODE_DOT && sel < 4)
          p = (j % n + $urandom_range(0, 2) + n - 1) % n;
        else
          p = $urandom_range(0, n - 1);
        sel = $urandom_range(0, 5);
        if (sel == 0) t = 32'($urandom_range(995, 1005));
        else if (sel == 1) t = 32'hFFFFFFFF - 32'($urandom_range(0, 3));
        else t = $urandom;
        queue_pixel(p, j, $urandom_range(0, 3), t);
      end
      total += cnt;
      phase++;
    end

    while (pix_requests.size() != 0 || exp_pixels.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (errors == 0 && exp_pixels.size() == 0) begin
      $display("PASS led_strip_pattern_generator_unit");
    end else begin
      $display("FAIL led_strip_pattern_generator_unit");
    end
    $finish;
  end

endmodule
